// ===== design/epsort_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsort_pkg
// Shared types, sizes and the ordering rule of the edge priority sorter.
// ----------------------------------------------------------------------------
package epsort_pkg;

	localparam int MAX_EDGES   = 64;
	localparam int VERTEX_BITS = 32;
	// stored vertex width: the field is 32 bits, so at most 32 bits survive
	localparam int VTX_W = (VERTEX_BITS < 32) ? VERTEX_BITS : 32;
	localparam int CNT_W = $clog2(MAX_EDGES + 1);

	typedef struct packed {
		logic [31:0]        vertex_a;
		logic [31:0]        vertex_b;
		logic signed [31:0] edge_length;
		logic               on_geometry;
		logic               last_edge;
	} edge_item_t;

	typedef struct packed {
		logic [31:0]        out_vertex_a;
		logic [31:0]        out_vertex_b;
		logic signed [31:0] out_length;
		logic               out_last;
		logic               overflow;
	} result_item_t;

	typedef struct packed {
		logic               valid;
		logic               geo;
		logic signed [31:0] len;
		logic [VTX_W-1:0]   va;
		logic [VTX_W-1:0]   vb;
	} entry_t;

	localparam entry_t ENTRY_NONE = '0;

	// operation broadcast to every cell in the chain
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_op_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// a newly loaded edge goes ahead of a stored one on equal keys
	function automatic logic goes_first(entry_t fresh, entry_t held);
		logic res;
		if (fresh.geo != held.geo) begin
			res = fresh.geo;
		end else begin
			res = ($signed(fresh.len) >= $signed(held.len));
		end
		return res;
	endfunction

endpackage

// ===== design/epsort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsort_cell
// One slot of the insertion chain: keeps one edge, takes the new edge or its
// left neighbour's edge on insert, takes its right neighbour's edge on shift.
// ----------------------------------------------------------------------------
module epsort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  epsort_pkg::cell_op_t op,
	input  epsort_pkg::entry_t   new_entry,
	input  epsort_pkg::entry_t   left_entry,
	input  logic                left_ins,
	input  epsort_pkg::entry_t   right_entry,
	output epsort_pkg::entry_t   entry,
	output logic                ins
);
	import epsort_pkg::*;

	logic   valid_q;
	entry_t data_q;

	// new edge belongs here or further left
	assign ins = !valid_q || goes_first(new_entry, entry);

	always_comb begin
		entry       = data_q;
		entry.valid = valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.shift) begin
			valid_q <= right_entry.valid;
		end else if (op.insert) begin
			if (left_ins) begin
				valid_q <= left_entry.valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.shift) begin
			data_q <= right_entry;
		end else if (op.insert) begin
			if (left_ins) begin
				data_q <= left_entry;
			end else if (ins) begin
				data_q <= new_entry;
			end
		end
	end

endmodule

// ===== design/edge_priority_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_priority_sorter_core
// Loads a list of edges into a sorted insertion chain, then drains it in
// order: geometry edges first, longest first, later loads first on ties.
// ----------------------------------------------------------------------------
// loading: one edge per cycle, each placed by a broadcast compare in the chain
// after the closing transfer the state moves to draining and the head is registered as the first result
// draining: one result per cycle from the chain head while the result side accepts; until the
// last stored edge has left the head, no edge is taken
// reset: chain empty, count and overflow cleared, no result pending
module edge_priority_sorter_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     edge_valid,
	output logic                     edge_ready,
	input  epsort_pkg::edge_item_t   edge_data,
	output logic                     result_valid,
	input  logic                     result_ready,
	output epsort_pkg::result_item_t result_data
);
	import epsort_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               overflow_q;
	logic               out_valid_q;
	result_item_t       out_q;

	logic               in_fire, full, insert_en, shift_en, last_out;
	cell_op_t           op;
	entry_t             new_entry;
	entry_t             cell_entry [MAX_EDGES];
	logic [MAX_EDGES-1:0] cell_ins;
	logic [MAX_EDGES-1:0] vld;

	assign full    = (count_q == CNT_W'(MAX_EDGES));
	assign in_fire = edge_valid && edge_ready;

	always_comb begin
		new_entry       = ENTRY_NONE;
		new_entry.valid = 1'b1;
		new_entry.geo   = edge_data.on_geometry;
		new_entry.len   = edge_data.edge_length;
		new_entry.va    = edge_data.vertex_a[VTX_W-1:0];
		new_entry.vb    = edge_data.vertex_b[VTX_W-1:0];
	end

	// final result when nothing is queued behind the head
	assign last_out = !vld[1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire && edge_data.last_edge) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (shift_en && last_out) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs of the control
	always_comb begin
		edge_ready = 1'b0;
		shift_en   = 1'b0;
		unique case (state_q)
			ST_LOAD:  edge_ready = 1'b1;
			ST_DRAIN: shift_en   = !out_valid_q || result_ready;
			default: begin
				edge_ready = 1'b0;
				shift_en   = 1'b0;
			end
		endcase
	end

	assign insert_en = in_fire && !full;
	assign op.insert = insert_en;
	assign op.shift  = shift_en;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_EDGES; gi++) begin : g_cell
			entry_t left_e, right_e;
			logic   left_i;
			if (gi == 0) begin : g_head
				assign left_e = ENTRY_NONE;
				assign left_i = 1'b0;
			end else begin : g_body
				assign left_e = cell_entry[gi-1];
				assign left_i = cell_ins[gi-1];
			end
			if (gi == MAX_EDGES - 1) begin : g_tail
				assign right_e = ENTRY_NONE;
			end else begin : g_mid
				assign right_e = cell_entry[gi+1];
			end
			epsort_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (op),
				.new_entry   (new_entry),
				.left_entry  (left_e),
				.left_ins    (left_i),
				.right_entry (right_e),
				.entry       (cell_entry[gi]),
				.ins         (cell_ins[gi])
			);
			assign vld[gi] = cell_entry[gi].valid;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift_en && last_out) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (in_fire) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (shift_en) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			out_q.out_vertex_a <= 32'(cell_entry[0].va);
			out_q.out_vertex_b <= 32'(cell_entry[0].vb);
			out_q.out_length   <= cell_entry[0].len;
			out_q.out_last     <= last_out;
			out_q.overflow     <= overflow_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	// occupied cells always form an unbroken run from the head
	a_no_holes: assert property (@(posedge clk) disable iff (!arst_n)
		((vld + MAX_EDGES'(1)) & vld) == '0)
		else $error("gap in sorter chain");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> $countones(vld) == 32'(count_q))
		else $error("edge count disagrees with chain occupancy");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> vld[0])
		else $error("draining an empty chain");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_EDGES))
		else $error("edge count past capacity");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sends edge lists of random and edge-case content into the sorter and checks
// every emitted edge against an in-bench ordering of the same list, under
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

	import epsort_pkg::*;

	localparam logic [31:0] VTX_MASK = (VTX_W >= 32) ? 32'hffff_ffff : ((32'd1 << VTX_W) - 1);
	localparam int unsigned ITEM_TARGET = 310;
	localparam int unsigned CALM_FROM   = 260;

	class sorted_edge_board;
		edge_item_t   held[MAX_EDGES];
		int unsigned  held_count = 0;
		bit           store_overrun = 0;
		result_item_t edges_due[$];
		int unsigned  mismatches = 0;

		// true when held edge j leaves the block ahead of held edge i
		function bit emitted_ahead(int unsigned j, int unsigned i);
			if (held[j].on_geometry != held[i].on_geometry)
				return held[j].on_geometry;
			if ($signed(held[j].edge_length) != $signed(held[i].edge_length))
				return $signed(held[j].edge_length) > $signed(held[i].edge_length);
			return j > i;
		endfunction

		function void load_edge(edge_item_t e);
			int unsigned  slot_of_rank[MAX_EDGES];
			int unsigned  rank;
			result_item_t r;
			if (held_count < MAX_EDGES) begin
				held[held_count] = e;
				held_count++;
			end else begin
				store_overrun = 1;
			end
			if (!e.last_edge)
				return;
			for (int unsigned i = 0; i < held_count; i++) begin
				rank = 0;
				for (int unsigned j = 0; j < held_count; j++)
					if (j != i && emitted_ahead(j, i))
						rank++;
				slot_of_rank[rank] = i;
			end
			for (int unsigned k = 0; k < held_count; k++) begin
				r.out_vertex_a = held[slot_of_rank[k]].vertex_a & VTX_MASK;
				r.out_vertex_b = held[slot_of_rank[k]].vertex_b & VTX_MASK;
				r.out_length   = held[slot_of_rank[k]].edge_length;
				r.out_last     = (k + 1 == held_count);
				r.overflow     = store_overrun;
				edges_due = {edges_due, r};
			end
			held_count = 0;
			store_overrun = 0;
		endfunction

		function void check_result(result_item_t got);
			result_item_t want;
			if (edges_due.size() == 0) begin
				$error("unexpected result transfer: va %h vb %h len %h", got.out_vertex_a,
					got.out_vertex_b, got.out_length);
				mismatches++;
				return;
			end
			want = edges_due.pop_front();
			if (got.out_vertex_a !== want.out_vertex_a) begin
				$error("out_vertex_a: expected %h, got %h", want.out_vertex_a, got.out_vertex_a);
				mismatches++;
			end
			if (got.out_vertex_b !== want.out_vertex_b) begin
				$error("out_vertex_b: expected %h, got %h", want.out_vertex_b, got.out_vertex_b);
				mismatches++;
			end
			if (got.out_length !== want.out_length) begin
				$error("out_length: expected %h, got %h", want.out_length, got.out_length);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %b, got %b", want.out_last, got.out_last);
				mismatches++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %b, got %b", want.overflow, got.overflow);
				mismatches++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         edge_valid;
	logic         edge_ready;
	edge_item_t   edge_data;
	logic         result_valid;
	logic         result_ready;
	result_item_t result_data;

	sorted_edge_board board;
	int unsigned      items_sent = 0;
	int unsigned      gap_pct = 0;
	int unsigned      stall_pct = 0;
	bit               calm = 0;

	edge_priority_sorter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.edge_valid   (edge_valid),
		.edge_ready   (edge_ready),
		.edge_data    (edge_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#500_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic edge_item_t make_edge(logic [31:0] va, logic [31:0] vb,
			logic [31:0] len, logic geo, logic last);
		edge_item_t e;
		e.vertex_a    = va;
		e.vertex_b    = vb;
		e.edge_length = len;
		e.on_geometry = geo;
		e.last_edge   = last;
		return e;
	endfunction

	function automatic edge_item_t random_edge();
		edge_item_t e;
		e.vertex_a    = $urandom;
		e.vertex_b    = $urandom;
		e.on_geometry = $urandom_range(0, 1);
		e.last_edge   = 1'b0;
		case ($urandom_range(0, 7))
			0: e.edge_length = 32'h7fff_ffff;
			1: e.edge_length = 32'h8000_0000;
			// narrow pool so equal lengths turn up often
			2, 3: e.edge_length = ($urandom_range(0, 3) << 16) - 32'h0001_0000;
			default: e.edge_length = $urandom;
		endcase
		return e;
	endfunction

	function automatic int unsigned pick_pace();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 25;
			default: return 60;
		endcase
	endfunction

	task automatic send_edge(edge_item_t e);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			edge_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		edge_valid <= 1'b1;
		edge_data  <= e;
		@(posedge clk);
		while (!edge_ready) @(posedge clk);
		board.load_edge(e);
		items_sent++;
	endtask

	task automatic send_list(int unsigned n);
		edge_item_t e;
		gap_pct   = pick_pace();
		stall_pct = pick_pace();
		for (int unsigned k = 0; k < n; k++) begin
			e = random_edge();
			e.last_edge = (k + 1 == n);
			send_edge(e);
		end
	endtask

	// result side: random stall bursts
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_result(result_data);
	end

	initial begin
		int unsigned n;
		board = new();
		arst_n     <= 1'b0;
		edge_valid <= 1'b0;
		edge_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-edge lists at the field extremes
		send_edge(make_edge(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 1'b1));
		send_edge(make_edge(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 1'b0, 1'b1));
		// mixed groups, ties in both groups, zero and the extremes
		gap_pct   = 25;
		stall_pct = 25;
		send_edge(make_edge(32'd1, 32'd2, 32'h0001_0000, 1'b0, 1'b0));
		send_edge(make_edge(32'd3, 32'd4, 32'h0001_0000, 1'b1, 1'b0));
		send_edge(make_edge(32'd5, 32'd6, 32'hffff_ffff, 1'b1, 1'b0));
		send_edge(make_edge(32'd7, 32'd8, 32'h0001_0000, 1'b0, 1'b0));
		send_edge(make_edge(32'd9, 32'd10, 32'h7fff_ffff, 1'b0, 1'b0));
		send_edge(make_edge(32'd11, 32'd12, 32'h8000_0000, 1'b1, 1'b0));
		send_edge(make_edge(32'd13, 32'd14, 32'h0000_0000, 1'b0, 1'b0));
		send_edge(make_edge(32'd15, 32'd16, 32'h0001_0000, 1'b1, 1'b1));
		// two identical edges: only load order separates them
		send_edge(make_edge(32'd0, 32'd0, 32'd0, 1'b0, 1'b0));
		send_edge(make_edge(32'd0, 32'd0, 32'd0, 1'b0, 1'b1));

		// a full store, then an overrun whose closing edge is dropped
		send_list(MAX_EDGES);
		send_list(MAX_EDGES + 2);
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= CALM_FROM)
				calm = 1;
			n = $urandom_range(1, 12);
			if (items_sent < 200 && $urandom_range(0, 19) == 0)
				n = MAX_EDGES + $urandom_range(0, 3);
			send_list(n);
		end
		edge_valid <= 1'b0;

		while (board.edges_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== edge_priority_sorter_core.f =====
design/epsort_pkg.sv
design/epsort_cell.sv
design/edge_priority_sorter_core.sv
tb/tb_top.sv
